FILE: rtl/core/qaq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaq_pkg
// Shared types, register indexes and helpers for the quality alert qualifier.
// ----------------------------------------------------------------------------
package qaq_pkg;

    localparam int QUALITY_W = 14;
    localparam int PCT_W     = 7;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAIL_HOST_SET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIPIENT_SET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS_NEEDED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS   = 3'd6;

    typedef struct packed
    {
        logic               alert_enable;
        logic               mail_host_set;
        logic               recipient_set;
        logic [PCT_W-1:0]   low_threshold;
        logic [PCT_W-1:0]   recover_level;
        logic [COUNT_W-1:0] low_ticks_needed;
        logic [COUNT_W-1:0] cooldown_ticks;
    } cfg_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0] low_ticks;
        logic [COUNT_W-1:0] cooldown_left;
        logic               signal_seen;
    } state_t;

    typedef struct packed
    {
        op_t                  operation;
        logic [QUALITY_W-1:0] quality;
        logic                 has_data;
    } tick_t;

    typedef struct packed
    {
        logic               alert;
        logic [COUNT_W-1:0] low_count;
        logic               in_cooldown;
    } result_t;

    // Percent to hundredths: x*100 = x*64 + x*32 + x*4, fits in 14 bits
    function automatic logic [QUALITY_W-1:0] pct_to_hundredths(input logic [PCT_W-1:0] pct);
        logic [QUALITY_W-1:0] x;
        x = {{(QUALITY_W-PCT_W){1'b0}}, pct};
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

endpackage

FILE: rtl/core/quality_alert_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_alert_qualifier
// Qualifies low-quality alerts with hysteresis, arming and cooldown.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per word: tuser is the operation (tick or clear),
//   tdata holds the quality sample and the data-valid flag. m_axis returns one
//   result word per tick: alert flag, low tick count and cooldown flag.
//   The cfg channel writes one register per word (index, data); it is always
//   ready and should only be used while no ticks are in flight.
// Pipeline and throughput:
//   Two register stages: an accepted tick sits in the input register, and its
//   result is loaded into the result register as it advances, then shown on
//   m_axis. One tick per cycle is sustained while m_axis is not stalled; the
//   state update is one pass of compare and increment logic between the stages.
// Reset:
//   rst_n clears the counters, the arming flag and both pipeline stages, and
//   loads the register defaults (monitoring off, no mail host, no recipient).
// Stall:
//   While m_axis_tready is low the result holds and the input register keeps
//   one more tick; s_axis_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
module quality_alert_qualifier
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qaq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qaq_pkg::CFG_DAT_W-1:0]       cfg_data,
    // tick input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [qaq_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // quality[13:0], has_data[14]
    input  logic                                s_axis_tuser,  // operation
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [qaq_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // alert[0], low_count[16:1],
                                                               // in_cooldown[17]
);

    qaq_pkg::cfg_t    cfg;
    qaq_pkg::state_t  state_reg;
    qaq_pkg::state_t  state_next;
    qaq_pkg::tick_t   tick_reg;
    qaq_pkg::result_t res_reg;
    qaq_pkg::result_t res_next;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;
    logic             s_accept;

    qaq_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qaq_step u_step
    (
        .cfg  (cfg),
        .cur  (state_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.in_cooldown, res_reg.low_count, res_reg.alert};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            tick_reg.operation <= qaq_pkg::op_t'(s_axis_tuser);
            tick_reg.quality   <= s_axis_tdata[qaq_pkg::QUALITY_W-1:0];
            tick_reg.has_data  <= s_axis_tdata[qaq_pkg::QUALITY_W];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Counter state moves only when a tick passes to the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("qualifier state changed without a tick");

    // An alert clears the count, so a running cooldown always sees a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cooldown_left != '0 |-> state_reg.low_ticks == '0)
        else $error("low count nonzero during cooldown");

    // A cooldown tick never reports an alert
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.in_cooldown |-> !res_reg.alert)
        else $error("alert reported on a cooldown tick");

    // A clear operation leaves all state at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && tick_reg.operation == qaq_pkg::OP_CLEAR |=> state_reg == '0)
        else $error("clear did not reset the qualifier state");

    // Both stages full with m_axis stalled means the input side must be stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("tick accepted with both stages full");

endmodule

FILE: rtl/core/qaq_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaq_cfg_regs
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module qaq_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qaq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qaq_pkg::CFG_DAT_W-1:0]   cfg_data,
    output qaq_pkg::cfg_t                   cfg
);

    qaq_pkg::cfg_t cfg_reg;
    qaq_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                qaq_pkg::REG_ALERT_ENABLE:     cfg_next.alert_enable     = cfg_data[0];
                qaq_pkg::REG_MAIL_HOST_SET:    cfg_next.mail_host_set    = cfg_data[0];
                qaq_pkg::REG_RECIPIENT_SET:    cfg_next.recipient_set    = cfg_data[0];
                qaq_pkg::REG_LOW_THRESHOLD:
                    cfg_next.low_threshold = cfg_data[qaq_pkg::PCT_W-1:0];
                qaq_pkg::REG_RECOVER_LEVEL:
                    cfg_next.recover_level = cfg_data[qaq_pkg::PCT_W-1:0];
                qaq_pkg::REG_LOW_TICKS_NEEDED: cfg_next.low_ticks_needed = cfg_data;
                qaq_pkg::REG_COOLDOWN_TICKS:   cfg_next.cooldown_ticks   = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alert_enable     <= 1'b0;
            cfg_reg.mail_host_set    <= 1'b0;
            cfg_reg.recipient_set    <= 1'b0;
            cfg_reg.low_threshold    <= 7'd50;
            cfg_reg.recover_level    <= 7'd70;
            cfg_reg.low_ticks_needed <= 16'd5;
            cfg_reg.cooldown_ticks   <= 16'd60;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/qaq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaq_step
// Next-state and result logic for one tick of the qualifier.
// ----------------------------------------------------------------------------
module qaq_step
(
    input  qaq_pkg::cfg_t   cfg,
    input  qaq_pkg::state_t cur,
    input  qaq_pkg::tick_t  tick,
    output qaq_pkg::state_t nxt,
    output qaq_pkg::result_t res
);

    logic [qaq_pkg::QUALITY_W-1:0] recover_hund;
    logic [qaq_pkg::QUALITY_W-1:0] thresh_hund;
    logic                          recovered;
    logic                          below;
    logic                          seen_upd;
    logic [qaq_pkg::COUNT_W-1:0]   count_inc;

    assign recover_hund = qaq_pkg::pct_to_hundredths(cfg.recover_level);
    assign thresh_hund  = qaq_pkg::pct_to_hundredths(cfg.low_threshold);
    assign recovered    = (tick.quality >= recover_hund);
    assign below        = (tick.quality < thresh_hund);
    assign seen_upd     = cur.signal_seen | recovered;
    assign count_inc    = (cur.low_ticks == qaq_pkg::COUNT_MAX) ? cur.low_ticks
                                                               : cur.low_ticks + 16'd1;

    always_comb
    begin
        nxt             = cur;
        res.alert       = 1'b0;
        res.in_cooldown = 1'b0;
        if (tick.operation == qaq_pkg::OP_CLEAR || !cfg.alert_enable)
        begin
            nxt = '0;
        end
        else if (!cfg.mail_host_set)
        begin
            nxt = cur;
        end
        else if (cur.cooldown_left != '0)
        begin
            // burn one cooldown tick
            nxt.cooldown_left = cur.cooldown_left - 16'd1;
            res.in_cooldown   = 1'b1;
        end
        else if (tick.has_data || cur.signal_seen)
        begin
            nxt.signal_seen = seen_upd;
            // a zero sample counts only once armed
            if (below && (seen_upd || tick.quality != '0))
            begin
                if (count_inc >= cfg.low_ticks_needed)
                begin
                    res.alert         = cfg.recipient_set;
                    nxt.low_ticks     = '0;
                    nxt.cooldown_left = cfg.cooldown_ticks;
                end
                else
                begin
                    nxt.low_ticks = count_inc;
                end
            end
            else if (recovered)
            begin
                nxt.low_ticks = '0;
            end
        end
        res.low_count = nxt.low_ticks;
    end

endmodule

FILE: tb/tb_quality_alert_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quality_alert_qualifier
// Self-checking bench for the low-quality alert qualifier. A short table of
// directed ticks and register writes covers the corner cases: disabled
// monitoring, clear, no mail host, arming, hysteresis, zero needed ticks,
// unreported alerts and extreme register values. Then several random
// register settings, each driven with runs of low samples, recoveries and
// noise. Every result word is checked against a table value or an in-bench
// predictor, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_quality_alert_qualifier;

    typedef enum logic [1:0]
    {
        ROW_WRITE,
        ROW_TICK,
        ROW_TICK_KNOWN
    } row_kind_t;

    typedef struct
    {
        row_kind_t                          kind;
        logic [qaq_pkg::CFG_IDX_W-1:0]      index;
        logic [qaq_pkg::CFG_DAT_W-1:0]      value;
        qaq_pkg::tick_t                     tick;
        qaq_pkg::result_t                   known;
    } row_t;

    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 250;
    localparam int LONG_HOLD       = 300;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [qaq_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [qaq_pkg::CFG_DAT_W-1:0]      cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [qaq_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;   // quality[13:0], has_data[14]
    logic                               s_axis_tuser = 1'b0; // operation
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [qaq_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // alert[0], low_count[16:1],
                                                             // in_cooldown[17]

    // predictor copy of the registers and the counters
    qaq_pkg::cfg_t    mon_cfg;
    qaq_pkg::state_t  mon_state;
    qaq_pkg::result_t results_due [$];

    row_t    directed_rows [$];
    int      errors = 0;
    int      ticks_sent = 0;
    int      settings_used = 0;
    int      results_checked = 0;
    int      alerts_seen = 0;
    int      cooldown_seen = 0;
    int      clears_sent = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;
    bit      long_hold_done = 1'b0;
    int      rx_hold = 0;
    qaq_pkg::result_t got_res;
    qaq_pkg::result_t exp_res;

    quality_alert_qualifier dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the predictor by one tick and return the result it produces
    function automatic qaq_pkg::result_t qualify_tick(input qaq_pkg::tick_t t);
        qaq_pkg::result_t res;
        int unsigned      q;
        int unsigned      low_level;
        int unsigned      ok_level;
        bit               recovered;
        bit               below;
        res = '0;
        q = t.quality;
        low_level = mon_cfg.low_threshold * 100;
        ok_level = mon_cfg.recover_level * 100;
        if (t.operation == qaq_pkg::OP_CLEAR || !mon_cfg.alert_enable)
        begin
            mon_state = '0;
        end
        else if (!mon_cfg.mail_host_set)
        begin
            // tick ignored, state held
        end
        else if (mon_state.cooldown_left != '0)
        begin
            mon_state.cooldown_left = mon_state.cooldown_left - 16'd1;
            res.in_cooldown = 1'b1;
        end
        else if (t.has_data || mon_state.signal_seen)
        begin
            recovered = (q >= ok_level);
            below = (q < low_level);
            if (recovered)
                mon_state.signal_seen = 1'b1;
            if (below && (mon_state.signal_seen || q > 0))
            begin
                if (mon_state.low_ticks < qaq_pkg::COUNT_MAX)
                    mon_state.low_ticks = mon_state.low_ticks + 16'd1;
                if (mon_state.low_ticks >= mon_cfg.low_ticks_needed)
                begin
                    res.alert = mon_cfg.recipient_set;
                    mon_state.low_ticks = '0;
                    mon_state.cooldown_left = mon_cfg.cooldown_ticks;
                end
            end
            else if (recovered)
            begin
                mon_state.low_ticks = '0;
            end
        end
        res.low_count = mon_state.low_ticks;
        return res;
    endfunction

    // Offer one tick; the expectation is taken at the accepting edge
    task automatic send_tick(input qaq_pkg::tick_t t, input bit use_known,
                             input qaq_pkg::result_t known);
        int               gap;
        qaq_pkg::result_t res;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, t.has_data, t.quality};
        s_axis_tuser  <= t.operation;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = qualify_tick(t);
        results_due.push_back(use_known ? known : res);
        ticks_sent++;
        if (t.operation == qaq_pkg::OP_CLEAR)
            clears_sent++;
    endtask

    // Stop offering and wait until every expected word is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [qaq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [qaq_pkg::CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            qaq_pkg::REG_ALERT_ENABLE:     mon_cfg.alert_enable     = value[0];
            qaq_pkg::REG_MAIL_HOST_SET:    mon_cfg.mail_host_set    = value[0];
            qaq_pkg::REG_RECIPIENT_SET:    mon_cfg.recipient_set    = value[0];
            qaq_pkg::REG_LOW_THRESHOLD:
                mon_cfg.low_threshold = value[qaq_pkg::PCT_W-1:0];
            qaq_pkg::REG_RECOVER_LEVEL:
                mon_cfg.recover_level = value[qaq_pkg::PCT_W-1:0];
            qaq_pkg::REG_LOW_TICKS_NEEDED: mon_cfg.low_ticks_needed = value;
            qaq_pkg::REG_COOLDOWN_TICKS:   mon_cfg.cooldown_ticks   = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Output side: check each word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_res.alert       = m_axis_tdata[0];
                got_res.low_count   = m_axis_tdata[16:1];
                got_res.in_cooldown = m_axis_tdata[17];
                results_checked++;
                if (got_res.alert)
                    alerts_seen++;
                if (got_res.in_cooldown)
                    cooldown_seen++;
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_res = results_due.pop_front();
                    if (got_res.alert !== exp_res.alert)
                    begin
                        $error("alert: expected %0d, got %0d", exp_res.alert, got_res.alert);
                        errors++;
                    end
                    if (got_res.low_count !== exp_res.low_count)
                    begin
                        $error("low_count: expected %0d, got %0d",
                               exp_res.low_count, got_res.low_count);
                        errors++;
                    end
                    if (got_res.in_cooldown !== exp_res.in_cooldown)
                    begin
                        $error("in_cooldown: expected %0d, got %0d",
                               exp_res.in_cooldown, got_res.in_cooldown);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && results_checked >= 700 && s_axis_tvalid)
            begin
                // hold off long enough for the block to fill and stall its input
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_steady)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                rx_hold = pick_gap();
                if (rx_hold > 0)
                    rx_hold--;
                m_axis_tready <= (rx_hold == 0) && ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        qaq_pkg::tick_t tk;
        int             kind;
        int             run_len;
        int             count;
        int unsigned    low_level;
        int unsigned    ok_level;

        directed_rows = '{
            '{ROW_TICK_KNOWN, '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd10000, 1'b1}, '0},
            '{ROW_TICK_KNOWN, '0, 16'd0, '{qaq_pkg::OP_CLEAR, 14'd0,     1'b0}, '0},
            '{ROW_WRITE, qaq_pkg::REG_ALERT_ENABLE,     16'd1,    '0, '0},
            '{ROW_TICK_KNOWN, '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b0}, '0},
            '{ROW_WRITE, qaq_pkg::REG_MAIL_HOST_SET,    16'd1,    '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_RECIPIENT_SET,    16'd1,    '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_LOW_TICKS_NEEDED, 16'd2,    '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_COOLDOWN_TICKS,   16'd1,    '0, '0},
            // not armed: zero samples are ignored with or without data
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b0}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd7000,  1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b0}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd5000,  1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd4999,  1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd16383, 1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd16383, 1'b1}, '0},
            '{ROW_TICK_KNOWN, '0, 16'd0, '{qaq_pkg::OP_CLEAR, 14'd16383, 1'b1}, '0},
            '{ROW_WRITE, qaq_pkg::REG_RECIPIENT_SET,    16'd0,    '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_LOW_TICKS_NEEDED, 16'd0,    '0, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd1,     1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd1,     1'b1}, '0},
            '{ROW_WRITE, qaq_pkg::REG_LOW_THRESHOLD,    16'd127,  '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_RECOVER_LEVEL,    16'd127,  '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_LOW_TICKS_NEEDED, 16'hFFFF, '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_COOLDOWN_TICKS,   16'hFFFF, '0, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd12699, 1'b1}, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd12700, 1'b1}, '0},
            '{ROW_WRITE, qaq_pkg::REG_LOW_THRESHOLD,    16'd0,    '0, '0},
            '{ROW_WRITE, qaq_pkg::REG_RECOVER_LEVEL,    16'd0,    '0, '0},
            '{ROW_TICK,       '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b1}, '0},
            '{ROW_WRITE, qaq_pkg::REG_ALERT_ENABLE,     16'd0,    '0, '0},
            '{ROW_TICK_KNOWN, '0, 16'd0, '{qaq_pkg::OP_TICK,  14'd0,     1'b1}, '0}
        };

        mon_cfg = '{alert_enable: 1'b0, mail_host_set: 1'b0, recipient_set: 1'b0,
                    low_threshold: 7'd50, recover_level: 7'd70,
                    low_ticks_needed: 16'd5, cooldown_ticks: 16'd60};
        mon_state = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings_used = 1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_register(directed_rows[i].index, directed_rows[i].value);
                settings_used++;
            end
            else
            begin
                send_tick(directed_rows[i].tick, directed_rows[i].kind == ROW_TICK_KNOWN,
                          directed_rows[i].known);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            // every other phase runs one side without gaps
            tx_steady = (ph % 4 == 1);
            rx_steady = (ph % 4 == 3);
            write_register(qaq_pkg::REG_ALERT_ENABLE,  16'($urandom_range(0, 9) != 0));
            write_register(qaq_pkg::REG_MAIL_HOST_SET, 16'($urandom_range(0, 9) != 0));
            write_register(qaq_pkg::REG_RECIPIENT_SET, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) != 0)
            begin
                write_register(qaq_pkg::REG_LOW_THRESHOLD, 16'($urandom_range(20, 60)));
                write_register(qaq_pkg::REG_RECOVER_LEVEL,
                               16'(mon_cfg.low_threshold + $urandom_range(0, 40)));
            end
            else
            begin
                write_register(qaq_pkg::REG_LOW_THRESHOLD, 16'($urandom_range(0, 127)));
                write_register(qaq_pkg::REG_RECOVER_LEVEL, 16'($urandom_range(0, 127)));
            end
            write_register(qaq_pkg::REG_LOW_TICKS_NEEDED,
                           16'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 6)
                                                           : $urandom_range(0, 65535)));
            write_register(qaq_pkg::REG_COOLDOWN_TICKS,
                           16'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 5)
                                                           : $urandom_range(20, 120)));
            settings_used++;
            low_level = mon_cfg.low_threshold * 100;
            ok_level = mon_cfg.recover_level * 100;

            count = 0;
            while (count < TICKS_PER_PHASE)
            begin
                kind = $urandom_range(0, 99);
                tk.operation = qaq_pkg::OP_TICK;
                if (kind < 45 && low_level > 0)
                begin
                    // run of low samples, of random length up to the needed ticks (at most 8) plus 3
                    run_len = $urandom_range(1, (mon_cfg.low_ticks_needed > 8 ? 8
                                               : mon_cfg.low_ticks_needed) + 3);
                    for (int k = 0; k < run_len; k++)
                    begin
                        tk.quality = ($urandom_range(0, 6) == 0) ? 14'd0
                                   : 14'($urandom_range(0, low_level - 1));
                        tk.has_data = ($urandom_range(0, 9) != 0);
                        send_tick(tk, 1'b0, '0);
                        count++;
                    end
                end
                else if (kind < 65)
                begin
                    tk.quality = 14'($urandom_range(ok_level, 16383));
                    tk.has_data = ($urandom_range(0, 9) != 0);
                    send_tick(tk, 1'b0, '0);
                    count++;
                end
                else if (kind < 80 && ok_level > low_level)
                begin
                    // hysteresis band: the count holds
                    tk.quality = 14'($urandom_range(low_level, ok_level - 1));
                    tk.has_data = 1'($urandom_range(0, 1));
                    send_tick(tk, 1'b0, '0);
                    count++;
                end
                else
                begin
                    tk.operation = ($urandom_range(0, 6) == 0) ? qaq_pkg::OP_CLEAR
                                                               : qaq_pkg::OP_TICK;
                    tk.quality = 14'($urandom_range(0, 16383));
                    tk.has_data = 1'($urandom_range(0, 1));
                    send_tick(tk, 1'b0, '0);
                    count++;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d expected result words never arrived", results_due.size());
            errors++;
        end
        $display("Covered %0d ticks (%0d clears) across %0d register settings.",
                 ticks_sent, clears_sent, settings_used);
        $display("Checked %0d result words: %0d reported alerts, %0d cooldown ticks.",
                 results_checked, alerts_seen, cooldown_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
